/* hw/rtl/rsa64_pkg.sv */
package rsa64_pkg;

	typedef logic mode_t;
	localparam mode_t MODE_MUL = 1'b0;
	localparam mode_t MODE_RED = 1'b1;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_KEY     = 2'd1;
	localparam status_t ST_PAD_VAL = 2'd2;
	localparam status_t ST_PAD_MIS = 2'd3;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_PUB_MOD = 2'd0;
	localparam reg_idx_t REG_PUB_EXP = 2'd1;
	localparam reg_idx_t REG_PRV_MOD = 2'd2;
	localparam reg_idx_t REG_PRV_EXP = 2'd3;

	localparam logic [3:0]  BLK_BYTES = 4'd8;
	localparam logic [7:0]  BYTE_MASK = 8'hFF;
	localparam logic [63:0] PAD_BLOCK = {8{8'h08}};

endpackage

/* hw/rtl/rsa64_mulmod.sv */
module rsa64_mulmod #(
	parameter int WORD_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  rsa64_pkg::mode_t       mode,
	input  logic [WORD_BITS-1:0]   x,
	input  logic [WORD_BITS-1:0]   y,
	input  logic [WORD_BITS-1:0]   n,
	output logic                   done,
	output logic [WORD_BITS-1:0]   res
);
	import rsa64_pkg::*;

	localparam int CW = $clog2(WORD_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	mode_t                mode_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] n_q;

	logic                 cin;
	logic [WORD_BITS:0]   dbl;
	logic [WORD_BITS:0]   dbl_sub;
	logic [WORD_BITS-1:0] a_nxt;
	logic [WORD_BITS:0]   sum;
	logic [WORD_BITS:0]   sum_sub;
	logic [WORD_BITS-1:0] acc_nxt;

	// doubling step (2a + bit) mod n, and accumulate step (acc + a) mod n
	always_comb begin
		cin     = (mode_q == MODE_RED) ? b_q[WORD_BITS-1] : 1'b0;
		dbl     = {a_q, cin};
		dbl_sub = dbl - {1'b0, n_q};
		a_nxt   = (dbl >= {1'b0, n_q}) ? dbl_sub[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
		sum     = {1'b0, acc_q} + {1'b0, a_q};
		sum_sub = sum - {1'b0, n_q};
		acc_nxt = (sum >= {1'b0, n_q}) ? sum_sub[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= MODE_MUL;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(WORD_BITS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				mode_q <= mode;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WORD_BITS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			acc_q <= '0;
			if (mode == MODE_RED) begin
				a_q <= '0;
				b_q <= x;
			end else begin
				a_q <= x;
				b_q <= y;
			end
		end else if (busy_q) begin
			a_q <= a_nxt;
			if (mode_q == MODE_RED) begin
				b_q <= b_q << 1;
			end else begin
				b_q <= b_q >> 1;
				if (b_q[0]) begin
					acc_q <= acc_nxt;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = (mode_q == MODE_RED) ? a_q : acc_q;

endmodule

/* hw/rtl/rsa64_block_modexp_cipher_top.sv */
// RSA block cipher on 64-bit big-endian blocks. Load the four key registers
// over the cfg port while idle. cmd 0 encrypts (final block padded to 8 bytes,
// a full final block adds a second result holding the encrypted pad block);
// cmd 1 decrypts and checks the padding of the final block. One block at a
// time: in_ready is high only when the exponent sequencer is idle, while the
// output register may still hold an untaken result. All modular arithmetic
// runs on one shared shift-add multiplier: an exponentiation runs one
// reduction, then one multiply per set exponent bit and one squaring per
// bit below the highest set one; a full final encrypt block runs two
// exponentiations. A zero modulus or exponent gives one status result.
module rsa64_block_modexp_cipher_top #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  rsa64_pkg::reg_idx_t  cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [63:0]          in_block,
	input  logic [3:0]           in_bytes,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          out_block,
	output logic [3:0]           out_bytes,
	output logic                 out_last,
	output rsa64_pkg::status_t   status
);
	import rsa64_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RED  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_SQR  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [63:0] pub_mod_q, pub_exp_q, prv_mod_q, prv_exp_q;

	logic [2:0]           state_q;
	logic                 start_q;
	logic                 cmd_q, last_q, zero_q, two_q, second_q;
	logic [WORD_BITS-1:0] x_q, acc_q, e_q, e_key_q, n_q;

	logic        out_valid_q, out_last_q;
	logic [63:0] out_block_q;
	logic [3:0]  out_bytes_q;
	status_t     status_q;

	logic                 accept;
	logic [WORD_BITS-1:0] sel_n, sel_e;
	logic                 key_zero;
	logic [3:0]           nb_clip;
	logic [7:0]           padv;
	logic                 full_pad;
	logic [63:0]          blk_in;

	mode_t                mm_mode;
	logic [WORD_BITS-1:0] mm_x, mm_res;
	logic                 mm_done;

	logic [63:0] m64, cleared;
	logic [7:0]  pad;
	logic        pad_bad, pad_mis;
	logic [63:0] res_block;
	logic [3:0]  res_bytes;
	logic        res_last;
	status_t     res_status;
	logic        out_free;
	logic        fin_take;
	logic        start_nxt;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign fin_take  = (state_q == S_FIN) && out_free;

	// kick the shared unit on every new operation
	assign start_nxt = (accept && !key_zero)
		|| (mm_done && (state_q == S_RED || state_q == S_SQR))
		|| (mm_done && state_q == S_MUL && e_q[WORD_BITS-1:1] != '0)
		|| (fin_take && two_q && !second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_mod_q <= '0;
			pub_exp_q <= '0;
			prv_mod_q <= '0;
			prv_exp_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PUB_MOD: pub_mod_q <= cfg_data;
				REG_PUB_EXP: pub_exp_q <= cfg_data;
				REG_PRV_MOD: prv_mod_q <= cfg_data;
				REG_PRV_EXP: prv_exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// key select and encrypt padding
	always_comb begin
		sel_n    = cmd ? prv_mod_q[WORD_BITS-1:0] : pub_mod_q[WORD_BITS-1:0];
		sel_e    = cmd ? prv_exp_q[WORD_BITS-1:0] : pub_exp_q[WORD_BITS-1:0];
		key_zero = (sel_n == '0) || (sel_e == '0);
		nb_clip  = (in_bytes > BLK_BYTES) ? BLK_BYTES : in_bytes;
		padv     = {4'd0, BLK_BYTES - nb_clip};
		full_pad = !cmd && in_last && (nb_clip == BLK_BYTES);
		blk_in   = in_block;
		if (!cmd && in_last && (nb_clip != BLK_BYTES)) begin
			for (int i = 0; i < 8; i++) begin
				if (4'(i) >= nb_clip) begin
					blk_in[63-8*i -: 8] = padv;
				end
			end
		end
	end

	assign mm_mode = (state_q == S_RED) ? MODE_RED : MODE_MUL;
	assign mm_x    = (state_q == S_MUL) ? acc_q : x_q;

	rsa64_mulmod #(
		.WORD_BITS (WORD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.mode   (mm_mode),
		.x      (mm_x),
		.y      (x_q),
		.n      (n_q),
		.done   (mm_done),
		.res    (mm_res)
	);

	// result formatting and pad check
	always_comb begin
		m64     = 64'(acc_q);
		pad     = m64[7:0] & BYTE_MASK;
		pad_bad = (pad == 8'd0) || (pad > {4'd0, BLK_BYTES});
		pad_mis = 1'b0;
		cleared = m64;
		for (int i = 0; i < 8; i++) begin
			if (8'(i) < pad) begin
				if (m64[8*i +: 8] != pad) begin
					pad_mis = 1'b1;
				end
				cleared[8*i +: 8] = 8'd0;
			end
		end
		res_block  = m64;
		res_bytes  = BLK_BYTES;
		res_status = ST_OK;
		res_last   = second_q || (last_q && !two_q);
		if (zero_q) begin
			res_block  = '0;
			res_bytes  = 4'd0;
			res_status = ST_KEY;
			res_last   = last_q;
		end else if (cmd_q && last_q) begin
			if (pad_bad) begin
				res_bytes  = 4'd0;
				res_status = ST_PAD_VAL;
			end else if (pad_mis) begin
				res_bytes  = 4'd0;
				res_status = ST_PAD_MIS;
			end else begin
				res_block = cleared;
				res_bytes = BLK_BYTES - pad[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cmd_q       <= 1'b0;
			last_q      <= 1'b0;
			zero_q      <= 1'b0;
			two_q       <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			start_q     <= start_nxt;
			out_valid_q <= fin_take || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd;
						last_q   <= in_last;
						zero_q   <= key_zero;
						two_q    <= full_pad && !key_zero;
						second_q <= 1'b0;
						if (key_zero) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (mm_done) begin
						state_q <= e_q[0] ? S_MUL : S_SQR;
					end
				end
				S_MUL: begin
					if (mm_done) begin
						if (e_q[WORD_BITS-1:1] == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SQR;
						end
					end
				end
				S_SQR: begin
					if (mm_done) begin
						state_q <= e_q[1] ? S_MUL : S_SQR;
					end
				end
				S_FIN: begin
					if (out_free) begin
						if (two_q && !second_q) begin
							second_q <= 1'b1;
							state_q  <= S_RED;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= blk_in[WORD_BITS-1:0];
			n_q     <= sel_n;
			e_q     <= sel_e;
			e_key_q <= sel_e;
			acc_q   <= WORD_BITS'(sel_n != WORD_BITS'(1));
		end
		if (mm_done) begin
			if (state_q == S_RED) begin
				x_q <= mm_res;
			end else if (state_q == S_MUL) begin
				acc_q <= mm_res;
			end else if (state_q == S_SQR) begin
				x_q <= mm_res;
				e_q <= e_q >> 1;
			end
		end
		if (state_q == S_FIN && out_free) begin
			out_block_q <= res_block;
			out_bytes_q <= res_bytes;
			out_last_q  <= res_last;
			status_q    <= res_status;
			if (two_q && !second_q) begin
				x_q   <= PAD_BLOCK[WORD_BITS-1:0];
				e_q   <= e_key_q;
				acc_q <= WORD_BITS'(n_q != WORD_BITS'(1));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_block = out_block_q;
	assign out_bytes = out_bytes_q;
	assign out_last  = out_last_q;
	assign status    = status_q;

endmodule
